@@ rtl/knn_pkg.sv @@
// shared types and constants of the nearest neighbour classifier
`timescale 1ns / 1ps
package knn_pkg;

  localparam int FEAT_W    = 24;
  localparam int LABEL_W   = 8;
  localparam int OP_W      = 2;
  localparam int DIST_W    = 56;
  localparam int KCFG_W    = 5;
  localparam int NFCFG_W   = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_CNT_W = 12;

  localparam logic [OP_W-1:0] OP_TRAIN = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_K  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NF = 1'b1;

  localparam logic [KCFG_W-1:0]  K_RESET  = 5'd10;
  localparam logic [NFCFG_W-1:0] NF_RESET = 7'd16;

  // 10000.0 squared in the 16 fraction bit distance format
  localparam logic [DIST_W-1:0] BOUND_SQ = DIST_W'(64'd100000000 << 16);

  typedef struct packed {
    logic take;
    logic zf_train;
    logic zf_query;
    logic cnt_inc;
    logic cls_init;
    logic vec_begin;
    logic feed;
    logic scan;
    logic update;
    logic vote_begin;
    logic vote_pick;
    logic vote_count;
    logic vote_close;
    logic vote_skip;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic last;
    logic room;
    logic zf_end;
    logic feed_last;
    logic pipe_empty;
    logic slot_last;
    logic j_last;
    logic vec_last;
    logic count_zero;
    logic slot_filled;
    logic out_free;
  } status_t;

endpackage

@@ rtl/knn_if.sv @@
// valid/ready channels for feature items and classification results
`timescale 1ns / 1ps
interface knn_in_if;
  logic                                valid;
  logic                                ready;
  logic [knn_pkg::OP_W-1:0]            operation;
  logic signed [knn_pkg::FEAT_W-1:0]   feature_value;
  logic [knn_pkg::LABEL_W-1:0]         class_label;
  logic                                last_feature;

  modport source(output valid, output operation, output feature_value,
                 output class_label, output last_feature, input ready);
  modport sink(input valid, input operation, input feature_value,
               input class_label, input last_feature, output ready);
endinterface

interface knn_out_if;
  logic                              valid;
  logic                              ready;
  logic [knn_pkg::LABEL_W-1:0]       predicted_label;
  logic                              no_neighbour;
  logic [knn_pkg::OUT_CNT_W-1:0]     vectors_stored;

  modport source(output valid, output predicted_label, output no_neighbour,
                 output vectors_stored, input ready);
  modport sink(input valid, input predicted_label, input no_neighbour,
               input vectors_stored, output ready);
endinterface

@@ rtl/knn_ram.sv @@
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module knn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/knn_ctrl.sv @@
// sequencing state machine of the classifier
`timescale 1ns / 1ps
module knn_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  knn_pkg::status_t st,
  output knn_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ZFT   = 4'd1;
  localparam logic [3:0] S_ZFQ   = 4'd2;
  localparam logic [3:0] S_CINIT = 4'd3;
  localparam logic [3:0] S_VBEG  = 4'd4;
  localparam logic [3:0] S_FEED  = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;
  localparam logic [3:0] S_VOTB  = 4'd9;
  localparam logic [3:0] S_VOTS  = 4'd10;
  localparam logic [3:0] S_VOTJ  = 4'd11;
  localparam logic [3:0] S_VOTC  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take = 1'b1;
          if (st.last && st.op == knn_pkg::OP_TRAIN && st.room) begin
            state_next = S_ZFT;
          end else if (st.last && st.op == knn_pkg::OP_QUERY) begin
            state_next = S_ZFQ;
          end
        end
      end
      S_ZFT: begin
        if (st.zf_end) begin
          cmd.cnt_inc = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.zf_train = 1'b1;
        end
      end
      S_ZFQ: begin
        if (st.zf_end) begin
          state_next = S_CINIT;
        end else begin
          cmd.zf_query = 1'b1;
        end
      end
      S_CINIT: begin
        cmd.cls_init = 1'b1;
        state_next = st.count_zero ? S_VOTB : S_VBEG;
      end
      S_VBEG: begin
        cmd.vec_begin = 1'b1;
        state_next = S_FEED;
      end
      S_FEED: begin
        cmd.feed = 1'b1;
        if (st.feed_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (st.pipe_empty) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.slot_last) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = st.vec_last ? S_VOTB : S_VBEG;
      end
      S_VOTB: begin
        cmd.vote_begin = 1'b1;
        state_next = S_VOTS;
      end
      S_VOTS: begin
        if (st.slot_filled) begin
          cmd.vote_pick = 1'b1;
          state_next = S_VOTJ;
        end else begin
          cmd.vote_skip = 1'b1;
          if (st.slot_last) begin
            state_next = S_FIN;
          end
        end
      end
      S_VOTJ: begin
        cmd.vote_count = 1'b1;
        if (st.j_last) begin
          state_next = S_VOTC;
        end
      end
      S_VOTC: begin
        cmd.vote_close = 1'b1;
        state_next = st.slot_last ? S_FIN : S_VOTS;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/knn_datapath.sv @@
// storage, distance pipeline, neighbour slots and vote of the classifier
`timescale 1ns / 1ps
module knn_datapath #(
  parameter int MAX_VECTORS  = 2048,
  parameter int MAX_FEATURES = 64,
  parameter int MAX_K        = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  knn_pkg::cmd_t                         cmd,
  output knn_pkg::status_t                      st,
  input  logic [knn_pkg::OP_W-1:0]              operation,
  input  logic signed [knn_pkg::FEAT_W-1:0]     feature_value,
  input  logic [knn_pkg::LABEL_W-1:0]           class_label,
  input  logic                                  last_feature,
  input  logic                                  cfg_we,
  input  logic [knn_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [knn_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [knn_pkg::LABEL_W-1:0]           predicted_label,
  output logic                                  no_neighbour,
  output logic [knn_pkg::OUT_CNT_W-1:0]         vectors_stored
);

  localparam int FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int PW  = $clog2(MAX_FEATURES + 1);
  localparam int VW  = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam int CW  = $clog2(MAX_VECTORS + 1);
  localparam int SW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int KW  = $clog2(MAX_K + 1);
  localparam int TAW = VW + FW;
  localparam int TDEPTH = MAX_VECTORS * (2 ** FW);
  localparam int FEAT_W = knn_pkg::FEAT_W;
  localparam int DIST_W = knn_pkg::DIST_W;
  localparam int LABEL_W = knn_pkg::LABEL_W;
  localparam int SQ_W = 2 * FEAT_W + 1;

  logic [knn_pkg::KCFG_W-1:0]  k_neighbours;
  logic [knn_pkg::NFCFG_W-1:0] num_features;
  logic [PW-1:0] nf_eff, nf_last;
  logic [KW-1:0] k_eff, k_last;

  logic [CW-1:0] count;
  logic [PW-1:0] pos, pos_inc, fill, zf, f;
  logic [CW-1:0] vec;
  logic [SW-1:0] s, j, far;
  logic [DIST_W-1:0] far_dist, acc;
  logic v1, v2, v3;
  logic signed [FEAT_W:0] diff;
  logic [SQ_W-1:0] sq;
  logic signed [2*FEAT_W+1:0] prod;

  logic [DIST_W-1:0]  slot_dist   [MAX_K];
  logic [LABEL_W-1:0] slot_lab    [MAX_K];
  logic               slot_filled [MAX_K];
  logic [SW-1:0]      rd_idx;
  logic [DIST_W-1:0]  rd_dist;
  logic [LABEL_W-1:0] rd_lab;
  logic               rd_filled;

  logic [LABEL_W-1:0] cur_lab, best_lab;
  logic [KW-1:0]      cnt, best_cnt;
  logic               any;

  logic room, wr_feat, take_feat;
  logic t_we, q_we, l_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [FEAT_W-1:0] t_wdata, q_wdata, t_rdata, q_rdata;
  logic [FW-1:0] q_waddr;
  logic [LABEL_W-1:0] l_rdata;

  always_comb begin
    if (num_features == '0) begin
      nf_eff = PW'(1);
    end else if (32'(num_features) > MAX_FEATURES) begin
      nf_eff = PW'(MAX_FEATURES);
    end else begin
      nf_eff = PW'(num_features);
    end
    if (k_neighbours == '0) begin
      k_eff = KW'(1);
    end else if (32'(k_neighbours) > MAX_K) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = KW'(k_neighbours);
    end
  end

  assign nf_last = nf_eff - PW'(1);
  assign k_last  = k_eff - KW'(1);
  assign room    = count < CW'(MAX_VECTORS);
  assign pos_inc = (pos < PW'(MAX_FEATURES)) ? pos + PW'(1) : pos;
  assign fill    = (pos_inc < nf_eff) ? pos_inc : nf_eff;
  assign wr_feat = pos < nf_eff;
  assign take_feat = cmd.take && wr_feat;

  assign t_we    = (take_feat && operation == knn_pkg::OP_TRAIN && room) || cmd.zf_train;
  assign t_waddr = cmd.zf_train ? {count[VW-1:0], zf[FW-1:0]} : {count[VW-1:0], pos[FW-1:0]};
  assign t_wdata = cmd.zf_train ? '0 : feature_value;
  assign t_raddr = {vec[VW-1:0], f[FW-1:0]};

  assign q_we    = (take_feat && operation == knn_pkg::OP_QUERY) || cmd.zf_query;
  assign q_waddr = cmd.zf_query ? zf[FW-1:0] : pos[FW-1:0];
  assign q_wdata = cmd.zf_query ? '0 : feature_value;

  assign l_we = cmd.take && operation == knn_pkg::OP_TRAIN && last_feature && room;

  knn_ram #(.WIDTH(FEAT_W), .DEPTH(TDEPTH)) u_train_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  knn_ram #(.WIDTH(FEAT_W), .DEPTH(2 ** FW)) u_query_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(f[FW-1:0]), .rdata(q_rdata)
  );

  knn_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_VECTORS)) u_label_ram (
    .clk(clk), .we(l_we), .waddr(count[VW-1:0]), .wdata(class_label),
    .raddr(vec[VW-1:0]), .rdata(l_rdata)
  );

  assign rd_idx    = cmd.vote_count ? j : s;
  assign rd_dist   = slot_dist[rd_idx];
  assign rd_lab    = slot_lab[rd_idx];
  assign rd_filled = slot_filled[rd_idx];
  assign prod      = diff * diff;

  assign st.op          = operation;
  assign st.last        = last_feature;
  assign st.room        = room;
  assign st.zf_end      = (zf == PW'(MAX_FEATURES));
  assign st.feed_last   = (f == nf_last);
  assign st.pipe_empty  = !v1 && !v2 && !v3;
  assign st.slot_last   = (KW'(s) == k_last);
  assign st.j_last      = (KW'(j) == k_last);
  assign st.vec_last    = ((vec + CW'(1)) == count);
  assign st.count_zero  = (count == '0);
  assign st.slot_filled = rd_filled;
  assign st.out_free    = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      k_neighbours <= knn_pkg::K_RESET;
      num_features <= knn_pkg::NF_RESET;
      count <= '0;
      pos <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_K; i++) begin
        slot_filled[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          knn_pkg::CFG_K:  k_neighbours <= cfg_data[knn_pkg::KCFG_W-1:0];
          knn_pkg::CFG_NF: num_features <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.take) begin
        case (operation)
          knn_pkg::OP_CLEAR: begin
            count <= '0;
            pos <= '0;
          end
          knn_pkg::OP_TRAIN, knn_pkg::OP_QUERY: begin
            pos <= last_feature ? '0 : pos_inc;
          end
          default: ;
        endcase
      end
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end
      v1 <= cmd.feed;
      v2 <= v1;
      v3 <= v2;
      if (cmd.cls_init) begin
        for (int i = 0; i < MAX_K; i++) begin
          slot_filled[i] <= 1'b0;
        end
      end else if (cmd.update && acc < far_dist) begin
        slot_filled[far] <= 1'b1;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      zf <= fill;
    end else if (cmd.zf_train || cmd.zf_query) begin
      zf <= zf + PW'(1);
    end
    if (cmd.cls_init) begin
      vec <= '0;
      for (int i = 0; i < MAX_K; i++) begin
        slot_dist[i] <= knn_pkg::BOUND_SQ;
      end
    end
    if (cmd.vec_begin) begin
      f <= '0;
      acc <= '0;
      s <= '0;
    end
    if (cmd.feed) begin
      f <= f + PW'(1);
    end
    if (v1) begin
      diff <= $signed({t_rdata[FEAT_W-1], t_rdata}) - $signed({q_rdata[FEAT_W-1], q_rdata});
    end
    if (v2) begin
      sq <= prod[SQ_W-1:0];
    end
    if (v3) begin
      acc <= acc + DIST_W'(sq);
    end
    if (cmd.scan) begin
      if (s == '0 || rd_dist > far_dist) begin
        far <= s;
        far_dist <= rd_dist;
      end
      s <= s + SW'(1);
    end
    if (cmd.update) begin
      if (acc < far_dist) begin
        slot_dist[far] <= acc;
        slot_lab[far] <= l_rdata;
      end
      vec <= vec + CW'(1);
    end
    if (cmd.vote_begin) begin
      s <= '0;
      any <= 1'b0;
      best_cnt <= '0;
      best_lab <= '0;
    end
    if (cmd.vote_pick) begin
      cur_lab <= rd_lab;
      cnt <= '0;
      j <= '0;
    end
    if (cmd.vote_count) begin
      if (rd_filled && rd_lab == cur_lab) begin
        cnt <= cnt + KW'(1);
      end
      j <= j + SW'(1);
    end
    if (cmd.vote_close) begin
      if (!any || cnt > best_cnt) begin
        any <= 1'b1;
        best_cnt <= cnt;
        best_lab <= cur_lab;
      end
      s <= s + SW'(1);
    end
    if (cmd.vote_skip) begin
      s <= s + SW'(1);
    end
    if (cmd.publish) begin
      predicted_label <= best_lab;
      no_neighbour <= !any;
      vectors_stored <= knn_pkg::OUT_CNT_W'(count);
    end
  end

endmodule

@@ rtl/knn_majority_classifier.sv @@
// top level of the k nearest neighbour classifier
//
// item channel: one feature per transfer; operation selects training feature,
// query feature or clearing the training store; last_feature closes a vector
// and a training vector takes its label from that transfer.
// result channel: one transfer per completed query vector.
// cfg port: cfg_we with cfg_index 0 writes k_neighbours, 1 writes num_features;
// write only while no item is in progress.
// a feature item that does not close a vector leaves the block ready for the
// next item. a last training feature, if the store has room, then zeroes the
// rest of the vector in the store. a last query feature zeroes the query the
// same way, then for every stored vector streams num_features reads from the
// single read port of the training ram through the distance pipeline and scans
// the k slots; the vote over the k slots follows.
// the result sits in an output register; while the receiver stalls the
// block finishes the query and waits, taking no new item until it is loaded.
// reset empties the training store, restores k = 10 and 16 features; store
// contents are not cleared and need no sweep.
`timescale 1ns / 1ps
module knn_majority_classifier #(
  parameter int MAX_VECTORS  = 2048,
  parameter int MAX_FEATURES = 64,
  parameter int MAX_K        = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  knn_in_if.sink                        item,
  knn_out_if.source                     result,
  input  logic                          cfg_we,
  input  logic [knn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [knn_pkg::CFG_W-1:0]     cfg_data
);

  knn_pkg::cmd_t    cmd;
  knn_pkg::status_t st;

  knn_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(item.valid), .in_ready(item.ready),
    .st(st), .cmd(cmd)
  );

  knn_datapath #(
    .MAX_VECTORS(MAX_VECTORS), .MAX_FEATURES(MAX_FEATURES), .MAX_K(MAX_K)
  ) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .operation(item.operation), .feature_value(item.feature_value),
    .class_label(item.class_label), .last_feature(item.last_feature),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_ready(result.ready), .out_valid(result.valid),
    .predicted_label(result.predicted_label), .no_neighbour(result.no_neighbour),
    .vectors_stored(result.vectors_stored)
  );

endmodule

@@ sim/tb_top.sv @@
// testbench of the k nearest neighbour classifier, checked by a class-based predictor
`timescale 1ns / 1ps
module tb_top;

  localparam int MAX_VEC   = 2048;
  localparam int MAX_FEAT  = 64;
  localparam int MAX_SLOTS = 16;
  localparam int WATCHDOG  = 20000;
  localparam logic [knn_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [knn_pkg::LABEL_W-1:0]   label;
    logic                          none;
    logic [knn_pkg::OUT_CNT_W-1:0] count;
  } verdict_t;

  class knn_scoreboard;
    bit signed [knn_pkg::FEAT_W-1:0] train_store [MAX_VEC][MAX_FEAT];
    bit [knn_pkg::LABEL_W-1:0]       train_label [MAX_VEC];
    bit signed [knn_pkg::FEAT_W-1:0] query_vec [MAX_FEAT];
    int unsigned            vec_count;
    int unsigned            feat_pos;
    int unsigned            k_reg;
    int unsigned            nf_reg;
    verdict_t               pending_results[$];
    int                     fails;

    function new();
      vec_count = 0;
      feat_pos  = 0;
      k_reg     = 10;
      nf_reg    = 16;
      fails     = 0;
    endfunction

    function int unsigned slots_used();
      return (k_reg < 1) ? 1 : (k_reg > MAX_SLOTS) ? MAX_SLOTS : k_reg;
    endfunction

    function int unsigned feats_used();
      return (nf_reg < 1) ? 1 : (nf_reg > MAX_FEAT) ? MAX_FEAT : nf_reg;
    endfunction

    function void predict_vote();
      longint unsigned slot_dist [MAX_SLOTS];
      bit [knn_pkg::LABEL_W-1:0] slot_lab [MAX_SLOTS];
      bit slot_full [MAX_SLOTS];
      int unsigned k, nf, far, cnt, best_cnt;
      longint unsigned sum;
      longint signed diff;
      bit any;
      verdict_t v;
      k  = slots_used();
      nf = feats_used();
      for (int s = 0; s < MAX_SLOTS; s++) begin
        slot_dist[s] = knn_pkg::BOUND_SQ;
        slot_full[s] = 0;
        slot_lab[s]  = '0;
      end
      for (int i = 0; i < vec_count; i++) begin
        sum = 0;
        for (int f = 0; f < nf; f++) begin
          diff = longint'(train_store[i][f]) - longint'(query_vec[f]);
          sum += longint'(diff * diff);
        end
        far = 0;
        for (int s = 1; s < k; s++)
          if (slot_dist[s] > slot_dist[far]) far = s;
        if (sum < slot_dist[far]) begin
          slot_dist[far] = sum;
          slot_lab[far]  = train_label[i];
          slot_full[far] = 1;
        end
      end
      any = 0;
      best_cnt = 0;
      v.label = '0;
      for (int s = 0; s < k; s++) begin
        if (!slot_full[s]) continue;
        cnt = 0;
        for (int j = 0; j < k; j++)
          if (slot_full[j] && slot_lab[j] == slot_lab[s]) cnt++;
        if (!any || cnt > best_cnt) begin
          any = 1;
          best_cnt = cnt;
          v.label = slot_lab[s];
        end
      end
      v.none  = !any;
      v.count = vec_count[knn_pkg::OUT_CNT_W-1:0];
      pending_results.push_back(v);
    endfunction

    function void note_item(logic [knn_pkg::OP_W-1:0] op,
                            logic signed [knn_pkg::FEAT_W-1:0] val,
                            logic [knn_pkg::LABEL_W-1:0] lab, logic last);
      int unsigned nf, fill;
      bit room;
      nf = feats_used();
      if (op == knn_pkg::OP_CLEAR) begin
        vec_count = 0;
        feat_pos  = 0;
        return;
      end
      if (op != knn_pkg::OP_TRAIN && op != knn_pkg::OP_QUERY) return;
      room = vec_count < MAX_VEC;
      if (feat_pos < nf) begin
        if (op == knn_pkg::OP_TRAIN) begin
          if (room) train_store[vec_count][feat_pos] = val;
        end else begin
          query_vec[feat_pos] = val;
        end
      end
      if (feat_pos < MAX_FEAT) feat_pos++;
      if (!last) return;
      fill = (feat_pos < nf) ? feat_pos : nf;
      if (op == knn_pkg::OP_TRAIN) begin
        if (room) begin
          for (int f = fill; f < MAX_FEAT; f++) train_store[vec_count][f] = 0;
          train_label[vec_count] = lab;
          vec_count++;
        end
        feat_pos = 0;
        return;
      end
      for (int f = fill; f < MAX_FEAT; f++) query_vec[f] = 0;
      feat_pos = 0;
      predict_vote();
    endfunction

    function void check_result(logic [knn_pkg::LABEL_W-1:0] lab, logic none,
                               logic [knn_pkg::OUT_CNT_W-1:0] cnt);
      verdict_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result label=%0d none=%0d stored=%0d",
                 $time, lab, none, cnt);
        fails++;
        return;
      end
      e = pending_results.pop_front();
      if (lab !== e.label) begin
        $display("%0t: predicted_label expected %0d actual %0d", $time, e.label, lab);
        fails++;
      end
      if (none !== e.none) begin
        $display("%0t: no_neighbour expected %0d actual %0d", $time, e.none, none);
        fails++;
      end
      if (cnt !== e.count) begin
        $display("%0t: vectors_stored expected %0d actual %0d", $time, e.count, cnt);
        fails++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [knn_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [knn_pkg::CFG_W-1:0] cfg_data = '0;

  knn_in_if  item ();
  knn_out_if result ();

  knn_majority_classifier DUT (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  knn_scoreboard sb = new();
  bit idle_on = 1;
  bit hold_req = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  initial begin
    item.valid = 0;
    item.operation = knn_pkg::OP_TRAIN;
    item.feature_value = '0;
    item.class_label = '0;
    item.last_feature = 0;
    result.ready = 0;
  end

  // monitor: results checked before the item of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (result.valid && result.ready)
        sb.check_result(result.predicted_label, result.no_neighbour, result.vectors_stored);
      if (item.valid && item.ready)
        sb.note_item(item.operation, item.feature_value, item.class_label,
                     item.last_feature);
    end
  end

  always @(posedge clk) begin
    if ((item.valid && item.ready) || (result.valid && result.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        result.ready <= 0;
        repeat (400) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result.ready <= 0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        result.ready <= 1;
        @(posedge clk);
      end
    end
  end

  function automatic logic signed [knn_pkg::FEAT_W-1:0] pick_feature();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 24'sh7FFFFF;
    if (r == 1) return 24'sh800000;
    if (r == 2) return knn_pkg::FEAT_W'($urandom);
    if (r < 8) return knn_pkg::FEAT_W'($urandom_range(0, 4000000) - 2000000);
    return knn_pkg::FEAT_W'($urandom_range(0, 6000) - 3000);
  endfunction

  function automatic logic [knn_pkg::LABEL_W-1:0] pick_label();
    return ($urandom_range(0, 7) == 0) ? knn_pkg::LABEL_W'($urandom)
                                       : knn_pkg::LABEL_W'($urandom_range(0, 3));
  endfunction

  task automatic send(logic [knn_pkg::OP_W-1:0] op, logic signed [knn_pkg::FEAT_W-1:0] val,
                      logic [knn_pkg::LABEL_W-1:0] lab, logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      item.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item.valid <= 1;
    item.operation <= op;
    item.feature_value <= val;
    item.class_label <= lab;
    item.last_feature <= last;
    do @(posedge clk); while (!item.ready);
  endtask

  task automatic send_vector(logic [knn_pkg::OP_W-1:0] op, int len,
                             logic [knn_pkg::LABEL_W-1:0] lab);
    for (int i = 0; i < len; i++)
      send(op, pick_feature(), lab, i == len - 1);
  endtask

  // query with training items mixed in; those land in the unused slot only
  task automatic send_mixed_query(int len);
    for (int i = 0; i < len; i++)
      send((i < len - 1 && $urandom_range(0, 3) == 0) ? knn_pkg::OP_TRAIN
                                                      : knn_pkg::OP_QUERY,
           pick_feature(), pick_label(), i == len - 1);
  endtask

  task automatic drain();
    item.valid <= 0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_regs(int k, int nf);
    cfg_we <= 1;
    cfg_index <= knn_pkg::CFG_K;
    cfg_data <= knn_pkg::CFG_W'(k);
    @(posedge clk);
    cfg_index <= knn_pkg::CFG_NF;
    cfg_data <= knn_pkg::CFG_W'(nf);
    @(posedge clk);
    cfg_we <= 0;
    sb.k_reg  = k & 'h1F;
    sb.nf_reg = nf & 'h7F;
    @(posedge clk);
  endtask

  task automatic random_phase(int k, int nf, int items);
    int sent, len, r;
    drain();
    write_regs(k, nf);
    send(knn_pkg::OP_CLEAR, '0, '0, 0);
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 19);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70)
                                        : $urandom_range(1, sb.feats_used() + 1);
      if (r < 12) begin
        if (sb.vec_count > 50) begin
          send(knn_pkg::OP_CLEAR, '0, '0, 0);
          sent++;
        end
        send_vector(knn_pkg::OP_TRAIN, len, pick_label());
      end else if (r < 16) begin
        send_vector(knn_pkg::OP_QUERY, len, pick_label());
      end else if (r < 18) begin
        send_mixed_query(len);
      end else if (r == 18) begin
        // training vector followed by a clear
        send_vector(knn_pkg::OP_TRAIN, len, pick_label());
        send(knn_pkg::OP_CLEAR, '0, '0, 0);
        len++;
      end else begin
        send(OP_UNUSED, pick_feature(), pick_label(), $urandom_range(0, 1));
        len = 0;
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // empty store, extremes, clear and the unused operation
    send(knn_pkg::OP_QUERY, 24'sh000100, 8'd0, 1);
    send(knn_pkg::OP_TRAIN, 24'sh7FFFFF, 8'd255, 1);
    send(knn_pkg::OP_TRAIN, 24'sh800000, 8'd0, 1);
    send(knn_pkg::OP_TRAIN, 24'sh000010, 8'd7, 0);
    send(knn_pkg::OP_TRAIN, -24'sh000020, 8'd7, 1);
    send(knn_pkg::OP_QUERY, 24'sh7FFFFF, 8'd0, 1);
    send(knn_pkg::OP_QUERY, 24'sh800000, 8'd0, 1);
    send(knn_pkg::OP_QUERY, 24'sh000011, 8'd0, 0);
    send(knn_pkg::OP_QUERY, -24'sh000011, 8'd0, 1);
    send(OP_UNUSED, 24'sh7FFFFF, 8'd255, 1);
    send(knn_pkg::OP_QUERY, 24'sh000000, 8'd0, 1);
    send(knn_pkg::OP_CLEAR, '0, '0, 1);
    send(knn_pkg::OP_QUERY, 24'sh000000, 8'd0, 1);
    drain();
    write_regs(1, 2);
    send(knn_pkg::OP_TRAIN, 24'sh000100, 8'd3, 0);
    send(knn_pkg::OP_TRAIN, 24'sh000100, 8'd3, 0);
    send(knn_pkg::OP_TRAIN, 24'sh7FFFFF, 8'd3, 1);
    send(knn_pkg::OP_TRAIN, 24'sh000050, 8'd9, 1);
    send(knn_pkg::OP_QUERY, 24'sh000100, 8'd0, 0);
    send(knn_pkg::OP_QUERY, 24'sh000100, 8'd0, 1);

    random_phase(1, 1, 150);
    random_phase(16, 64, 170);
    random_phase(0, 0, 150);
    random_phase(31, 127, 170);

    // receiver holds off while queries keep coming
    drain();
    hold_req = 1;
    for (int i = 0; i < 6; i++) begin
      send_vector(knn_pkg::OP_TRAIN, 3, pick_label());
      send_vector(knn_pkg::OP_QUERY, 3, 8'd0);
    end

    random_phase(5, 8, 170);
    random_phase(3, 4, 170);
    idle_on = 0;
    random_phase(16, 2, 310);

    drain();
    if (sb.fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/knn_pkg.sv
rtl/knn_if.sv
rtl/knn_ram.sv
rtl/knn_ctrl.sv
rtl/knn_datapath.sv
rtl/knn_majority_classifier.sv
sim/tb_top.sv
